// ----- hw/rtl/sorted_key_record_table_assert.svh -----
// ----------------------------------------------------------------------------
// sorted key record table assertion macros
// concurrent assertion wrappers on clk with synchronous active-low rst_n
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_RECORD_TABLE_ASSERT_SVH
`define SORTED_KEY_RECORD_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
`define SKLT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sklt assertion failed");
`define SKLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sklt assertion failed");
`else
`define SKLT_ASSERT_IMPL(label, ante, cons)
`define SKLT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hw/rtl/sklt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sklt_pkg
// shared types, codes and the name packing function of the record table
// ----------------------------------------------------------------------------
package sklt_pkg;

  localparam int NAME_LEN  = 19;
  localparam int NAME_BITS = 8 * NAME_LEN;
  localparam int KEY_W     = 32;

  typedef logic [NAME_BITS-1:0] name_t;

  typedef struct packed {
    name_t first;
    name_t last;
  } name_pair_t;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2
  } act_t;

  typedef struct packed {
    logic ok;
    logic table_empty;
    logic hit;
  } res_t;

  // bytes after the first zero byte are forced to zero
  function automatic name_t pack_name(input name_t raw);
    name_t r;
    logic  alive;
    alive = 1'b1;
    for (int i = 0; i < NAME_LEN; i++) begin
      alive       = alive & (|raw[8*i +: 8]);
      r[8*i +: 8] = alive ? raw[8*i +: 8] : 8'h00;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/sklt_name_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sklt_name_store
// name memory, one first/last name pair per record slot, registered read
// ----------------------------------------------------------------------------
module sklt_name_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  sklt_pkg::name_t     first_raw,
  input  sklt_pkg::name_t     last_raw,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output sklt_pkg::name_pair_t rdata
);
  import sklt_pkg::*;

  name_pair_t mem [DEPTH];
  name_pair_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= '{first: pack_name(first_raw), last: pack_name(last_raw)};
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/sklt_list_ctrl.sv -----
`timescale 1ns / 1ps
`include "sorted_key_record_table_assert.svh"
// ----------------------------------------------------------------------------
// sklt_list_ctrl
// sorted linked list of record slots: node memory (key, next), list walk,
// link and unlink, free slot list and command sequencing
// ----------------------------------------------------------------------------
module sklt_list_ctrl #(
  parameter int CAPACITY = 16,
  parameter int AW       = 4,
  parameter int CW       = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic signed [31:0] key,
  output logic               name_we,
  output logic [AW-1:0]      name_waddr,
  output logic               name_re,
  output logic [AW-1:0]      name_raddr,
  output logic               res_valid,
  input  logic               res_ready,
  output sklt_pkg::res_t     res
);
  import sklt_pkg::*;

  localparam int NW = KEY_W + AW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_SEARCH,
    ST_LINK,
    ST_FREE,
    ST_RESP
  } state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      free_head_r, free_head_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      fresh_r, fresh_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  act_t               act_r, act_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic [AW-1:0]      slot_r, slot_nxt;
  logic               slot_fresh_r, slot_fresh_nxt;
  logic [AW-1:0]      prev_r, prev_nxt;
  logic               prev_valid_r, prev_valid_nxt;
  logic signed [31:0] prev_key_r, prev_key_nxt;
  logic [AW-1:0]      cur_r, cur_nxt;
  logic               ok_r, ok_nxt;
  logic               hit_r, hit_nxt;

  logic [NW-1:0]      node_mem [CAPACITY];
  logic [NW-1:0]      nd_rdata_r;
  logic               nd_re, nd_we;
  logic [AW-1:0]      nd_raddr, nd_waddr;
  logic [NW-1:0]      nd_wdata;

  logic signed [31:0] rd_key;
  logic [AW-1:0]      rd_next;
  logic               free_avail, full, in_list;

  assign rd_key     = $signed(nd_rdata_r[KEY_W-1:0]);
  assign rd_next    = nd_rdata_r[NW-1:KEY_W];
  assign free_avail = fresh_r > count_r;
  assign full       = count_r == CW'(CAPACITY);
  assign in_list    = idx_r < count_r;

  assign in_ready  = state_r == ST_IDLE;
  assign res_valid = state_r == ST_RESP;
  assign res       = '{ok: ok_r, table_empty: count_r == '0, hit: hit_r};

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    free_head_nxt  = free_head_r;
    count_nxt      = count_r;
    fresh_nxt      = fresh_r;
    idx_nxt        = idx_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    slot_nxt       = slot_r;
    slot_fresh_nxt = slot_fresh_r;
    prev_nxt       = prev_r;
    prev_valid_nxt = prev_valid_r;
    prev_key_nxt   = prev_key_r;
    cur_nxt        = cur_r;
    ok_nxt         = ok_r;
    hit_nxt        = hit_r;
    nd_re          = 1'b0;
    nd_raddr       = head_r;
    nd_we          = 1'b0;
    nd_waddr       = slot_r;
    nd_wdata       = {cur_r, key_r};
    name_we        = 1'b0;
    name_waddr     = fresh_r[AW-1:0];
    name_re        = 1'b0;
    name_raddr     = cur_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          act_nxt        = act_t'(action);
          key_nxt        = key;
          prev_valid_nxt = 1'b0;
          cur_nxt        = head_r;
          idx_nxt        = '0;
          ok_nxt         = 1'b0;
          hit_nxt        = 1'b0;
          case (act_t'(action))
            ACT_INSERT: begin
              if (full) begin
                state_nxt = ST_RESP;
              end else begin
                slot_nxt       = free_avail ? free_head_r : fresh_r[AW-1:0];
                slot_fresh_nxt = !free_avail;
                name_we        = 1'b1;
                name_waddr     = free_avail ? free_head_r : fresh_r[AW-1:0];
                nd_re          = 1'b1;
                nd_raddr       = free_avail ? free_head_r : head_r;
                state_nxt      = free_avail ? ST_POP : ST_SEARCH;
              end
            end
            ACT_REMOVE, ACT_LOOKUP: begin
              nd_re     = 1'b1;
              nd_raddr  = head_r;
              state_nxt = ST_SEARCH;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      ST_POP: begin
        free_head_nxt = rd_next;
        nd_re         = 1'b1;
        nd_raddr      = head_r;
        state_nxt     = ST_SEARCH;
      end

      ST_SEARCH: begin
        if (in_list && (rd_key < key_r)) begin
          prev_nxt       = cur_r;
          prev_key_nxt   = rd_key;
          prev_valid_nxt = 1'b1;
          cur_nxt        = rd_next;
          idx_nxt        = idx_r + 1'b1;
          nd_re          = 1'b1;
          nd_raddr       = rd_next;
        end else begin
          state_nxt = ST_RESP;
          case (act_r)
            ACT_INSERT: begin
              nd_we     = 1'b1;
              nd_waddr  = slot_r;
              nd_wdata  = {cur_r, key_r};
              state_nxt = ST_LINK;
            end
            ACT_REMOVE: begin
              if (in_list && (rd_key == key_r)) begin
                if (prev_valid_r) begin
                  nd_we    = 1'b1;
                  nd_waddr = prev_r;
                  nd_wdata = {rd_next, prev_key_r};
                end else begin
                  head_nxt = rd_next;
                end
                state_nxt = ST_FREE;
              end
            end
            ACT_LOOKUP: begin
              if (in_list && (rd_key == key_r)) begin
                name_re    = 1'b1;
                name_raddr = cur_r;
                ok_nxt     = 1'b1;
                hit_nxt    = 1'b1;
              end
            end
            default: begin
              ok_nxt = 1'b0;
            end
          endcase
        end
      end

      ST_LINK: begin
        if (prev_valid_r) begin
          nd_we    = 1'b1;
          nd_waddr = prev_r;
          nd_wdata = {slot_r, prev_key_r};
        end else begin
          head_nxt = slot_r;
        end
        count_nxt = count_r + 1'b1;
        if (slot_fresh_r) begin
          fresh_nxt = fresh_r + 1'b1;
        end
        ok_nxt    = 1'b1;
        state_nxt = ST_RESP;
      end

      ST_FREE: begin
        nd_we         = 1'b1;
        nd_waddr      = cur_r;
        nd_wdata      = {free_head_r, key_r};
        free_head_nxt = cur_r;
        count_nxt     = count_r - 1'b1;
        ok_nxt        = 1'b1;
        state_nxt     = ST_RESP;
      end

      ST_RESP: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= '0;
      free_head_r  <= '0;
      count_r      <= '0;
      fresh_r      <= '0;
      idx_r        <= '0;
      act_r        <= ACT_INSERT;
      slot_fresh_r <= 1'b0;
      prev_valid_r <= 1'b0;
      ok_r         <= 1'b0;
      hit_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      free_head_r  <= free_head_nxt;
      count_r      <= count_nxt;
      fresh_r      <= fresh_nxt;
      idx_r        <= idx_nxt;
      act_r        <= act_nxt;
      slot_fresh_r <= slot_fresh_nxt;
      prev_valid_r <= prev_valid_nxt;
      ok_r         <= ok_nxt;
      hit_r        <= hit_nxt;
    end
    key_r      <= key_nxt;
    slot_r     <= slot_nxt;
    prev_r     <= prev_nxt;
    prev_key_r <= prev_key_nxt;
    cur_r      <= cur_nxt;
  end

  // node memory
  always_ff @(posedge clk) begin
    if (nd_we) begin
      node_mem[nd_waddr] <= nd_wdata;
    end
    if (nd_re) begin
      nd_rdata_r <= node_mem[nd_raddr];
    end
  end

  `SKLT_ASSERT_IMPL(a_count_cap, 1'b1, count_r <= CW'(CAPACITY))
  `SKLT_ASSERT_IMPL(a_count_fresh, 1'b1, count_r <= fresh_r)
  `SKLT_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state_r != ST_IDLE)
  `SKLT_ASSERT_NEXT(a_count_hold, state_r != ST_LINK && state_r != ST_FREE, $stable(count_r))

endmodule

// ----- hw/rtl/sorted_key_record_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_record_table
// Table of up to CAPACITY records kept in ascending signed key order, each
// with a 19-byte first and last name. Commands: insert, remove, look up.
//
// in channel: one command word per transfer, action in in_tuser, key and
// both names in in_tdata. out channel: one result word per command with
// ok, table_empty and the looked-up names (zero unless a lookup hits).
// Records live in a linked list over a node memory (key, next slot) and a
// name memory; a command walks the list from its head one node a cycle.
// An insert into a freed slot first pops the free list before its walk;
// an insert then links the new node in, and a remove that hits unlinks
// its node and returns the slot to the free list. A full-table insert or
// an unused action goes straight to its result. A new command is
// accepted once the previous result sits in the output register.
// Reset empties the table; record memories need no clearing.
// When out_tready is low the result word holds and the next result waits
// in the block, which then accepts no further command.
// ----------------------------------------------------------------------------
module sorted_key_record_table #(
  parameter int CAPACITY = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // key[31:0], first_a, first_b, first_c, last_a, last_b, last_c
  input  logic [335:0] in_tdata,
  // action[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // ok, table_empty, found_first_a, found_first_b, found_first_c,
  // found_last_a, found_last_b, found_last_c, zero pad
  output logic [311:0] out_tdata
);
  import sklt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic               name_we, name_re;
  logic [AW-1:0]      name_waddr, name_raddr;
  name_pair_t         name_rdata;
  logic               res_valid, res_ready;
  res_t               res;
  logic signed [31:0] in_key;
  name_t              in_first, in_last;

  logic               out_valid_r;
  logic               ok_r;
  logic               empty_r;
  name_pair_t         names_r;

  assign in_key   = $signed(in_tdata[31:0]);
  assign in_first = in_tdata[183:32];
  assign in_last  = in_tdata[335:184];

  sklt_list_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .action     (in_tuser),
    .key        (in_key),
    .name_we    (name_we),
    .name_waddr (name_waddr),
    .name_re    (name_re),
    .name_raddr (name_raddr),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  sklt_name_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_names (
    .clk       (clk),
    .we        (name_we),
    .waddr     (name_waddr),
    .first_raw (in_first),
    .last_raw  (in_last),
    .re        (name_re),
    .raddr     (name_raddr),
    .rdata     (name_rdata)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && res_ready) begin
      ok_r    <= res.ok;
      empty_r <= res.table_empty;
      names_r <= res.hit ? name_rdata : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, names_r.last, names_r.first, empty_r, ok_r};

endmodule

// ----- bench/sorted_key_record_table_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_record_table_checker
// Watches both stream channels of the record table. Every accepted command
// word runs through a behavioral copy of the sorted table and its result is
// queued; every accepted result word is compared field by field against the
// oldest queued result. Mismatch and queue depth counts go to the testbench.
// ----------------------------------------------------------------------------
module sorted_key_record_table_checker #(
  parameter int CAPACITY = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  // key[31:0], first_a, first_b, first_c, last_a, last_b, last_c
  input  logic [335:0] in_tdata,
  // action[1:0]
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  // ok, table_empty, found_first_a, found_first_b, found_first_c,
  // found_last_a, found_last_b, found_last_c, zero pad
  input  logic [311:0] out_tdata,
  output int           fail_count,
  output int           pending
);
  import sklt_pkg::*;

  typedef struct packed {
    logic  ok;
    logic  table_empty;
    name_t first;
    name_t last;
  } table_result_t;

  logic signed [31:0] entry_keys [CAPACITY];
  name_t              entry_first [CAPACITY];
  name_t              entry_last [CAPACITY];
  int                 entry_count;
  table_result_t      result_queue [$];
  int                 errors;

  initial begin
    fail_count = 0;
    pending    = 0;
    errors     = 0;
  end

  // a name ends at its first zero byte
  function automatic name_t truncate_name(input name_t raw);
    name_t keep;
    int    len;
    len  = NAME_LEN;
    keep = '0;
    for (int i = NAME_LEN - 1; i >= 0; i--)
      if (raw[8*i +: 8] == 8'h00) len = i;
    for (int i = 0; i < len; i++)
      keep[8*i +: 8] = raw[8*i +: 8];
    return keep;
  endfunction

  task automatic run_table_command(input logic [1:0] action, input logic signed [31:0] key,
                                   input name_t first_raw, input name_t last_raw,
                                   output table_result_t res);
    int pos;
    res = '0;
    pos = 0;
    while (pos < entry_count && entry_keys[pos] < key) pos++;
    case (action)
      ACT_INSERT: begin
        if (entry_count < CAPACITY) begin
          for (int j = entry_count; j > pos; j--) begin
            entry_keys[j]  = entry_keys[j-1];
            entry_first[j] = entry_first[j-1];
            entry_last[j]  = entry_last[j-1];
          end
          entry_keys[pos]  = key;
          entry_first[pos] = truncate_name(first_raw);
          entry_last[pos]  = truncate_name(last_raw);
          entry_count++;
          res.ok = 1'b1;
        end
      end
      ACT_REMOVE, ACT_LOOKUP: begin
        if (pos < entry_count && entry_keys[pos] == key) begin
          res.ok = 1'b1;
          if (action == ACT_LOOKUP) begin
            res.first = entry_first[pos];
            res.last  = entry_last[pos];
          end else begin
            for (int j = pos; j + 1 < entry_count; j++) begin
              entry_keys[j]  = entry_keys[j+1];
              entry_first[j] = entry_first[j+1];
              entry_last[j]  = entry_last[j+1];
            end
            entry_count--;
          end
        end
      end
      default: ;
    endcase
    res.table_empty = (entry_count == 0);
  endtask

  always @(posedge clk) begin
    table_result_t want;
    table_result_t got;
    table_result_t fresh;
    if (!rst_n) begin
      entry_count = 0;
      result_queue.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.ok          = out_tdata[0];
        got.table_empty = out_tdata[1];
        got.first       = out_tdata[153:2];
        got.last        = out_tdata[305:154];
        if (result_queue.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result word %h", out_tdata);
        end else begin
          want = result_queue.pop_front();
          if (got.ok !== want.ok || got.table_empty !== want.table_empty
              || got.first[63:0] !== want.first[63:0]
              || got.first[127:64] !== want.first[127:64]
              || got.first[151:128] !== want.first[151:128]
              || got.last[63:0] !== want.last[63:0]
              || got.last[127:64] !== want.last[127:64]
              || got.last[151:128] !== want.last[151:128]) begin
            errors++;
            if (errors <= 10) begin
              $display("result mismatch: ok %b/%b empty %b/%b (expected/actual)",
                       want.ok, got.ok, want.table_empty, got.table_empty);
              $display("  first expected %h actual %h", want.first, got.first);
              $display("  last  expected %h actual %h", want.last, got.last);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        run_table_command(in_tuser, in_tdata[31:0], in_tdata[183:32], in_tdata[335:184],
                          fresh);
        result_queue.push_back(fresh);
      end
    end
    pending    <= result_queue.size();
    fail_count <= errors;
  end

endmodule

// ----- bench/sorted_key_record_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_record_table_tb
// Drives table commands into the record table: a directed pass over the
// empty and full table, extreme keys, duplicates and zero-terminated names,
// then random commands on a small key pool so records hit and miss. Both
// channels stall at random; results are checked by the checker module.
// ----------------------------------------------------------------------------
module sorted_key_record_table_tb;
  import sklt_pkg::*;

  localparam int                 CAPACITY     = 16;
  localparam logic [1:0]         ACT_RESERVED = 2'd3;
  localparam int                 RANDOM_ITEMS = 700;
  localparam int                 DRAIN_CYCLES = 48;
  localparam int                 CYCLE_LIMIT  = 400000;
  localparam logic signed [31:0] KEY_MIN      = 32'sh80000000;
  localparam logic signed [31:0] KEY_MAX      = 32'sh7fffffff;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [335:0] in_tdata   = '0;
  logic [1:0]   in_tuser   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [311:0] out_tdata;
  logic         quiet      = 1'b0;
  int           fail_count;
  int           pending;

  sorted_key_record_table #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  sorted_key_record_table_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk)
    out_tready <= quiet || ($urandom_range(0, 99) >= 27);

  initial begin
    int cycle;
    for (cycle = 0; cycle < CYCLE_LIMIT; cycle++) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic name_t random_name();
    name_t n;
    int    cut;
    for (int i = 0; i < NAME_LEN; i++) n[8*i +: 8] = 8'($urandom);
    cut = $urandom_range(0, NAME_LEN - 1);
    case ($urandom_range(0, 3))
      0: n[8*cut +: 8] = 8'h00;
      1: for (int i = cut; i < NAME_LEN; i++) n[8*i +: 8] = 8'h00;
      default: ;
    endcase
    return n;
  endfunction

  task automatic send_command(input logic [1:0] action, input logic signed [31:0] key,
                              input name_t first, input name_t last);
    while (!quiet && $urandom_range(0, 99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= action;
    in_tdata  <= {last, first, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    name_t              inner;
    logic signed [31:0] key_pool [20];
    logic signed [31:0] key;
    logic [1:0]         act;
    int                 roll;
    int                 ins_pct;

    inner = {NAME_LEN{8'h5a}};
    inner[8*7 +: 8] = 8'h00;
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = 0;
    key_pool[3] = -1;
    key_pool[4] = 1;
    for (int i = 5; i < 20; i++) key_pool[i] = $urandom;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table
    send_command(ACT_LOOKUP, 0, '0, '0);
    send_command(ACT_REMOVE, KEY_MAX, '1, '1);
    send_command(ACT_RESERVED, -1, '1, '1);
    // fill to capacity with extremes, duplicates and cut names
    send_command(ACT_INSERT, KEY_MIN, '1, '1);
    send_command(ACT_INSERT, KEY_MAX, '0, '0);
    send_command(ACT_INSERT, 0, inner, random_name());
    send_command(ACT_INSERT, 0, random_name(), inner);
    send_command(ACT_INSERT, -1, random_name(), random_name());
    for (int i = 0; i < CAPACITY - 5; i++)
      send_command(ACT_INSERT, $urandom, random_name(), random_name());
    send_command(ACT_INSERT, 1, '1, '1);
    send_command(ACT_LOOKUP, 0, '0, '0);
    send_command(ACT_LOOKUP, KEY_MIN, '0, '0);
    send_command(ACT_LOOKUP, KEY_MAX, '0, '0);
    send_command(ACT_REMOVE, 0, '0, '0);
    send_command(ACT_LOOKUP, 0, '0, '0);
    send_command(ACT_RESERVED, KEY_MIN, '1, '1);
    send_command(ACT_LOOKUP, 1234567, '0, '0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet   <= (i >= 300 && i < 450);
      roll    = $urandom_range(0, 99);
      ins_pct = ((i / 60) % 2 == 0) ? 60 : 25;
      if (roll < 3)
        act = ACT_RESERVED;
      else if (roll < 3 + ins_pct)
        act = ACT_INSERT;
      else if (roll < 3 + ins_pct + (97 - ins_pct) / 2)
        act = ACT_REMOVE;
      else
        act = ACT_LOOKUP;
      if ($urandom_range(0, 99) < 85)
        key = key_pool[$urandom_range(0, 19)];
      else
        key = $urandom;
      send_command(act, key, random_name(), random_name());
    end
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/sklt_pkg.sv
hw/rtl/sklt_name_store.sv
hw/rtl/sklt_list_ctrl.sv
hw/rtl/sorted_key_record_table.sv
bench/sorted_key_record_table_checker.sv
bench/sorted_key_record_table_tb.sv
